FILE: hw/rtl/atc_pkg.sv
`timescale 1ns / 1ps

package atc_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int ITERS        = 32;
	localparam int ITER_W       = $clog2(ITERS);
	localparam int Q_DEPTH      = 2;
	localparam logic [30:0] KINV_Q31 = 31'd1304065748;

	localparam logic CMD_MOVE = 1'b0;
	localparam logic CMD_LINE = 1'b1;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        rad;
		logic               arc;
		logic               ccw;
		logic               first;
		logic [31:0]        a0;
		logic [31:0]        span;
		logic [SEG_W-1:0]   segnum;
	} atc_desc_t;

	// arctangent of 2^-i, a full turn is 2^32
	function automatic logic [31:0] atan_lut(input logic [ITER_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/arc_tessellator_unit.sv
`timescale 1ns / 1ps
// Flow: a line edge passes straight through the front into the queue; an arc first
// goes through two 32-step angle CORDICs in the front, then the back runs the divide.
// Each interior arc point goes once around the 32-step rotating CORDIC; the front can
// take a new edge while the back still emits the points of an earlier one.
// Reset: arst_n clears the queue and both sequencers; num_segments resets to 64.
module arc_tessellator_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [31:0]        start_x,
	input  logic signed [31:0]        start_y,
	input  logic signed [31:0]        end_x,
	input  logic signed [31:0]        end_y,
	input  logic signed [31:0]        center_x,
	input  logic signed [31:0]        center_y,
	input  logic [30:0]               radius,
	input  logic                      is_arc,
	input  logic                      counter_clockwise,
	input  logic                      first_edge,
	input  logic                      cfg_we,
	input  logic [atc_pkg::SEG_W-1:0] cfg_wdata,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        point_x,
	output logic signed [31:0]        point_y,
	output logic                      command,
	output logic                      last
);

	logic [atc_pkg::SEG_W-1:0] num_segments_q;
	atc_pkg::atc_desc_t        f_desc, q_desc;
	logic                      q_push, q_pop, q_full, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_segments_q <= atc_pkg::SEG_W'(atc_pkg::MAX_SEGMENTS);
		else if (cfg_we) num_segments_q <= cfg_wdata;
	end

	atc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.start_x, .start_y, .end_x, .end_y, .center_x, .center_y,
		.radius, .is_arc, .counter_clockwise, .first_edge,
		.num_segments (num_segments_q),
		.desc         (f_desc),
		.push         (q_push),
		.q_full       (q_full)
	);

	atc_fifo u_fifo (
		.clk, .arst_n,
		.push    (q_push),
		.wr_data (f_desc),
		.pop     (q_pop),
		.rd_data (q_desc),
		.full    (q_full),
		.empty   (q_empty)
	);

	atc_back u_back (
		.clk, .arst_n,
		.desc    (q_desc),
		.q_empty (q_empty),
		.pop     (q_pop),
		.out_valid, .out_stall, .point_x, .point_y, .command, .last
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> num_segments_q == $past(cfg_wdata))
		else $error("configuration write lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_empty)
		else $error("queue full and empty at once");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y))
		else $error("stalled point changed or dropped");

endmodule

FILE: hw/rtl/atc_front.sv
`timescale 1ns / 1ps

module atc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [31:0]           start_x,
	input  logic signed [31:0]           start_y,
	input  logic signed [31:0]           end_x,
	input  logic signed [31:0]           end_y,
	input  logic signed [31:0]           center_x,
	input  logic signed [31:0]           center_y,
	input  logic [30:0]                  radius,
	input  logic                         is_arc,
	input  logic                         counter_clockwise,
	input  logic                         first_edge,
	input  logic [atc_pkg::SEG_W-1:0]    num_segments,
	output atc_pkg::atc_desc_t           desc,
	output logic                         push,
	input  logic                         q_full
);

	typedef enum logic [2:0] {
		F_IDLE, F_LOAD0, F_ITER0, F_LOAD1, F_ITER1, F_SPAN, F_SEG, F_PUSH
	} fstate_t;

	fstate_t                      state_q;
	logic [atc_pkg::ITER_W-1:0]   cnt_q;
	atc_pkg::atc_desc_t           item_q;
	logic signed [35:0]           vx_q, vy_q;
	logic signed [33:0]           vz_q;
	logic                         zero_q;

	logic signed [31:0]           px, py;
	logic signed [32:0]           dx, dy;
	logic signed [35:0]           dx_w, dy_w, xs, ys;
	logic signed [33:0]           at;
	logic [31:0]                  ang;
	logic [atc_pkg::SEG_W-1:0]    nseg;
	logic [atc_pkg::SEG_W+31:0]   prod;
	logic                         accept;

	assign accept   = in_valid && (state_q == F_IDLE);
	assign in_stall = (state_q != F_IDLE);
	assign push     = (state_q == F_PUSH) && !q_full;
	assign desc     = item_q;

	assign px   = (state_q == F_LOAD0) ? item_q.sx : item_q.ex;
	assign py   = (state_q == F_LOAD0) ? item_q.sy : item_q.ey;
	assign dx   = $signed({px[31], px}) - $signed({item_q.cx[31], item_q.cx});
	assign dy   = $signed({py[31], py}) - $signed({item_q.cy[31], item_q.cy});
	assign dx_w = {{3{dx[32]}}, dx};
	assign dy_w = {{3{dy[32]}}, dy};
	assign xs   = vx_q >>> cnt_q;
	assign ys   = vy_q >>> cnt_q;
	assign at   = $signed({2'b00, atc_pkg::atan_lut(cnt_q)});
	assign ang  = zero_q ? 32'd0 : vz_q[31:0];
	assign nseg = (num_segments > atc_pkg::SEG_W'(atc_pkg::MAX_SEGMENTS)) ?
		atc_pkg::SEG_W'(atc_pkg::MAX_SEGMENTS) : num_segments;
	assign prod = (atc_pkg::SEG_W+32)'(nseg) * (atc_pkg::SEG_W+32)'(item_q.span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) state_q <= is_arc ? F_LOAD0 : F_PUSH;
				end
				F_LOAD0: begin
					cnt_q   <= '0;
					state_q <= F_ITER0;
				end
				F_ITER0: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == atc_pkg::ITER_W'(atc_pkg::ITERS - 1)) state_q <= F_LOAD1;
				end
				F_LOAD1: begin
					cnt_q   <= '0;
					state_q <= F_ITER1;
				end
				F_ITER1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == atc_pkg::ITER_W'(atc_pkg::ITERS - 1)) state_q <= F_SPAN;
				end
				F_SPAN: state_q <= F_SEG;
				F_SEG:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!q_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					item_q.sx     <= start_x;
					item_q.sy     <= start_y;
					item_q.ex     <= end_x;
					item_q.ey     <= end_y;
					item_q.cx     <= center_x;
					item_q.cy     <= center_y;
					item_q.rad    <= radius;
					item_q.arc    <= is_arc;
					item_q.ccw    <= counter_clockwise;
					item_q.first  <= first_edge;
					item_q.a0     <= '0;
					item_q.span   <= '0;
					item_q.segnum <= '0;
				end
			end
			F_LOAD0, F_LOAD1: begin
				if (state_q == F_LOAD1) item_q.a0 <= ang;
				zero_q <= (dx == 33'sd0) && (dy == 33'sd0);
				// fold the left half plane over by a half turn
				if (dx[32]) begin
					vx_q <= -dx_w;
					vy_q <= -dy_w;
					vz_q <= 34'sh080000000;
				end else begin
					vx_q <= dx_w;
					vy_q <= dy_w;
					vz_q <= '0;
				end
			end
			F_ITER0, F_ITER1: begin
				if (!vy_q[35]) begin
					vx_q <= vx_q + ys;
					vy_q <= vy_q - xs;
					vz_q <= vz_q + at;
				end else begin
					vx_q <= vx_q - ys;
					vy_q <= vy_q + xs;
					vz_q <= vz_q - at;
				end
			end
			F_SPAN: begin
				item_q.span <= item_q.ccw ? (ang - item_q.a0) : (item_q.a0 - ang);
			end
			F_SEG: begin
				item_q.segnum <= prod[atc_pkg::SEG_W+31:32];
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("front took a transaction without going busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PUSH) && item_q.arc |-> item_q.segnum < nseg || nseg == '0)
		else $error("segment count not below the segments per turn");
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !in_stall)
		else $error("front did not return to idle after handing off");

endmodule

FILE: hw/rtl/atc_fifo.sv
`timescale 1ns / 1ps

module atc_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  atc_pkg::atc_desc_t wr_data,
	input  logic               pop,
	output atc_pkg::atc_desc_t rd_data,
	output logic               full,
	output logic               empty
);

	localparam int PTR_W = (atc_pkg::Q_DEPTH > 1) ? $clog2(atc_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(atc_pkg::Q_DEPTH + 1);

	atc_pkg::atc_desc_t mem_q [atc_pkg::Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full    = (count_q == CNT_W'(atc_pkg::Q_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(atc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(atc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> !empty)
		else $error("queue empty after a push");

endmodule

FILE: hw/rtl/atc_back.sv
`timescale 1ns / 1ps

module atc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  atc_pkg::atc_desc_t desc,
	input  logic               q_empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic               command,
	output logic               last
);

	typedef enum logic [3:0] {
		B_IDLE, B_MOVE, B_DIV, B_KMUL, B_X0, B_STEP, B_RLOAD, B_ROT, B_PT, B_END
	} bstate_t;

	localparam int SW = atc_pkg::SEG_W;

	bstate_t                    state_q;
	logic [atc_pkg::ITER_W-1:0] cnt_q;
	logic [SW-1:0]              k_q;

	atc_pkg::atc_desc_t d_q;
	logic [31:0]        divd_q, quo_q, acc_q;
	logic [SW-1:0]      rem_q, accr_q;
	logic [61:0]        prod_q;
	logic signed [41:0] x0_q, rx_q, ry_q;
	logic signed [33:0] rz_q;
	logic               flip_q;

	logic               out_free, has_int;
	logic [SW:0]        remsh, accs;
	logic               div_ge, acc_ge;
	logic [31:0]        ang;
	logic signed [33:0] zs, at;
	logic signed [41:0] xs, ys, fx, fy;
	logic signed [33:0] xr, yr;
	logic signed [34:0] sx, sy;
	logic signed [31:0] qx, qy;
	logic [62:0]        x0_sum;

	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == B_IDLE) && !q_empty;
	assign has_int  = d_q.arc && (d_q.segnum >= SW'(2));

	assign remsh  = {rem_q, divd_q[31]};
	assign div_ge = remsh >= {1'b0, d_q.segnum};
	assign accs   = {1'b0, accr_q} + {1'b0, rem_q};
	assign acc_ge = accs >= {1'b0, d_q.segnum};
	assign ang    = d_q.ccw ? (d_q.a0 + acc_q) : (d_q.a0 - acc_q);
	assign zs     = {{2{ang[31]}}, ang};
	assign at     = $signed({2'b00, atc_pkg::atan_lut(cnt_q)});
	assign xs     = rx_q >>> cnt_q;
	assign ys     = ry_q >>> cnt_q;
	assign x0_sum = {1'b0, prod_q} + 63'(1 << 22);

	// round off the guard bits, move to the centre and clamp
	assign fx = flip_q ? -rx_q : rx_q;
	assign fy = flip_q ? -ry_q : ry_q;
	assign xr = 34'((fx + 42'sd128) >>> 8);
	assign yr = 34'((fy + 42'sd128) >>> 8);
	assign sx = {{3{d_q.cx[31]}}, d_q.cx} + {xr[33], xr};
	assign sy = {{3{d_q.cy[31]}}, d_q.cy} + {yr[33], yr};
	assign qx = (sx > 35'sh07FFFFFFF) ? 32'sh7FFFFFFF :
		(sx < -35'sh080000000) ? 32'sh80000000 : sx[31:0];
	assign qy = (sy > 35'sh07FFFFFFF) ? 32'sh7FFFFFFF :
		(sy < -35'sh080000000) ? 32'sh80000000 : sy[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			cnt_q     <= '0;
			k_q       <= '0;
			out_valid <= 1'b0;
			point_x   <= '0;
			point_y   <= '0;
			command   <= atc_pkg::CMD_MOVE;
			last      <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					cnt_q <= '0;
					if (!q_empty) begin
						if (desc.first) state_q <= B_MOVE;
						else if (desc.arc && desc.segnum >= SW'(2)) state_q <= B_DIV;
						else state_q <= B_END;
					end
				end
				B_MOVE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						point_x   <= d_q.sx;
						point_y   <= d_q.sy;
						command   <= atc_pkg::CMD_MOVE;
						last      <= 1'b0;
						state_q   <= has_int ? B_DIV : B_END;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == atc_pkg::ITER_W'(atc_pkg::ITERS - 1)) state_q <= B_KMUL;
				end
				B_KMUL: state_q <= B_X0;
				B_X0: begin
					k_q     <= SW'(1);
					state_q <= B_STEP;
				end
				B_STEP: state_q <= B_RLOAD;
				B_RLOAD: begin
					cnt_q   <= '0;
					state_q <= B_ROT;
				end
				B_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == atc_pkg::ITER_W'(atc_pkg::ITERS - 1)) state_q <= B_PT;
				end
				B_PT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						point_x   <= qx;
						point_y   <= qy;
						command   <= atc_pkg::CMD_LINE;
						last      <= 1'b0;
						if (k_q == d_q.segnum - SW'(1)) begin
							state_q <= B_END;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= B_STEP;
						end
					end
				end
				B_END: begin
					if (out_free) begin
						out_valid <= 1'b1;
						point_x   <= d_q.ex;
						point_y   <= d_q.ey;
						command   <= atc_pkg::CMD_LINE;
						last      <= 1'b1;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					d_q    <= desc;
					divd_q <= desc.span;
					rem_q  <= '0;
					quo_q  <= '0;
				end
			end
			B_DIV: begin
				// one quotient bit of span / segnum a cycle
				divd_q <= {divd_q[30:0], 1'b0};
				rem_q  <= div_ge ? SW'(remsh - {1'b0, d_q.segnum}) : SW'(remsh);
				quo_q  <= {quo_q[30:0], div_ge};
			end
			B_KMUL: prod_q <= 62'(d_q.rad) * 62'(atc_pkg::KINV_Q31);
			B_X0: begin
				x0_q   <= $signed({2'b00, x0_sum[62:23]});
				acc_q  <= '0;
				accr_q <= '0;
			end
			B_STEP: begin
				// step k = k*quo + floor(k*rem / segnum), carried forward
				acc_q  <= acc_q + quo_q + 32'(acc_ge);
				accr_q <= acc_ge ? SW'(accs - {1'b0, d_q.segnum}) : SW'(accs);
			end
			B_RLOAD: begin
				rx_q <= x0_q;
				ry_q <= '0;
				if (zs > 34'sh040000000) begin
					rz_q   <= zs - 34'sh080000000;
					flip_q <= 1'b1;
				end else if (zs < -34'sh040000000) begin
					rz_q   <= zs + 34'sh080000000;
					flip_q <= 1'b1;
				end else begin
					rz_q   <= zs;
					flip_q <= 1'b0;
				end
			end
			B_ROT: begin
				if (!rz_q[33]) begin
					rx_q <= rx_q - ys;
					ry_q <= ry_q + xs;
					rz_q <= rz_q - at;
				end else begin
					rx_q <= rx_q + ys;
					ry_q <= ry_q - xs;
					rz_q <= rz_q + at;
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_PT) |-> has_int && k_q >= SW'(1) && k_q < d_q.segnum)
		else $error("interior point index out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != B_IDLE)
		else $error("back end idle after taking a descriptor");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> command == atc_pkg::CMD_LINE)
		else $error("edge closed by a move-to");

endmodule
